// ===== rtl/sucr_pkg.sv =====
`default_nettype none

package sucr_pkg;

  localparam int unsigned DATA_W = 32;

  localparam logic [DATA_W-1:0] KEY_FIRST       = 32'hAA99_6655;
  localparam logic [DATA_W-1:0] KEY_SECOND      = 32'h5566_99AA;
  localparam logic [DATA_W-1:0] OSC_CTRL_RESET  = 32'h0145_3320;
  localparam logic [DATA_W-1:0] DEVICE_ID_RESET = 32'h0430_7053;

  localparam int unsigned WR_BIT   = 15;
  localparam int unsigned WREN_BIT = 14;

  localparam logic [3:0] OP_ERASE   = 4'h4;
  localparam logic [3:0] OP_PROGRAM = 4'h1;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [3:0] IX_OSC_CTRL    = 4'd0;
  localparam logic [3:0] IX_OSC_TUNE    = 4'd1;
  localparam logic [3:0] IX_DEBUG_PORT  = 4'd2;
  localparam logic [3:0] IX_DEV_ID      = 4'd3;
  localparam logic [3:0] IX_SYSKEY      = 4'd4;
  localparam logic [3:0] IX_RESET_CAUSE = 4'd5;
  localparam logic [3:0] IX_SW_RESET    = 4'd6;
  localparam logic [3:0] IX_NVM_CTRL    = 4'd7;
  localparam logic [3:0] IX_NVM_KEY     = 4'd8;
  localparam logic [3:0] IX_NVM_ADDR    = 4'd9;
  localparam logic [3:0] IX_NVM_DATA    = 4'd10;
  localparam logic [3:0] IX_NVM_SRC     = 4'd11;

  typedef enum logic [1:0] {
    WK_ASSIGN = 2'd0,
    WK_CLEAR  = 2'd1,
    WK_SET    = 2'd2,
    WK_INVERT = 2'd3
  } wkind_t;

  typedef enum logic [1:0] {
    STEP_IDLE = 2'd0,
    STEP_KEY1 = 2'd1,
    STEP_KEY2 = 2'd2
  } step_t;

  typedef struct packed {
    logic              command;
    logic [3:0]        reg_index;
    logic [1:0]        write_kind;
    logic [DATA_W-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              soft_reset_pulse;
    logic              flash_request;
    logic              flash_kind;
    logic [DATA_W-1:0] flash_address;
    logic [DATA_W-1:0] flash_word;
    logic              unsupported_op;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/sucr_item_if.sv =====
`default_nettype none

interface sucr_item_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [3:0]  reg_index;
  logic [1:0]  write_kind;
  logic [31:0] write_data;

  modport source (output valid, command, reg_index, write_kind, write_data, input ready);
  modport sink (input valid, command, reg_index, write_kind, write_data, output ready);
endinterface

`default_nettype wire

// ===== rtl/sucr_result_if.sv =====
`default_nettype none

interface sucr_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        soft_reset_pulse;
  logic        flash_request;
  logic        flash_kind;
  logic [31:0] flash_address;
  logic [31:0] flash_word;
  logic        unsupported_op;

  modport source (output valid, read_data, soft_reset_pulse, flash_request, flash_kind,
                  flash_address, flash_word, unsupported_op, input ready);
  modport sink (input valid, read_data, soft_reset_pulse, flash_request, flash_kind,
                flash_address, flash_word, unsupported_op, output ready);
endinterface

`default_nettype wire

// ===== rtl/sucr_regs.sv =====
`default_nettype none

module sucr_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        fire,
  input  wire sucr_pkg::item_t             item,
  input  wire logic [sucr_pkg::DATA_W-1:0] device_id,
  output sucr_pkg::result_t                res
);
  import sucr_pkg::*;

  logic [DATA_W-1:0] osc_ctrl;
  logic [DATA_W-1:0] osc_tune;
  logic [DATA_W-1:0] debug_port;
  logic [DATA_W-1:0] syskey;
  logic [DATA_W-1:0] reset_cause;
  logic [DATA_W-1:0] sw_reset;
  logic [DATA_W-1:0] nvm_ctrl;
  logic [DATA_W-1:0] nvm_key;
  logic [DATA_W-1:0] nvm_addr;
  logic [DATA_W-1:0] nvm_data;
  logic [DATA_W-1:0] nvm_src;
  step_t             sys_step;
  step_t             sys_step_next;
  step_t             flash_step;
  step_t             flash_step_next;

  logic [DATA_W-1:0] old_val;
  logic [DATA_W-1:0] wval;
  logic              mapped;
  logic              is_wr;
  logic              nvm_sel;
  logic              key1_hit;

  always_comb begin
    old_val = '0;
    mapped  = 1'b1;
    case (item.reg_index)
      IX_OSC_CTRL:    old_val = osc_ctrl;
      IX_OSC_TUNE:    old_val = osc_tune;
      IX_DEBUG_PORT:  old_val = debug_port;
      IX_DEV_ID:      old_val = device_id;
      IX_SYSKEY:      old_val = syskey;
      IX_RESET_CAUSE: old_val = reset_cause;
      IX_SW_RESET:    old_val = sw_reset;
      IX_NVM_CTRL:    old_val = nvm_ctrl;
      IX_NVM_KEY:     old_val = nvm_key;
      IX_NVM_ADDR:    old_val = nvm_addr;
      IX_NVM_DATA:    old_val = nvm_data;
      IX_NVM_SRC:     old_val = nvm_src;
      default:        mapped = 1'b0;
    endcase

    is_wr   = (item.command == CMD_WRITE);
    nvm_sel = item.reg_index inside {[IX_NVM_CTRL:IX_NVM_SRC]};

    wval = item.write_data;
    if (nvm_sel) begin
      case (wkind_t'(item.write_kind))
        WK_ASSIGN: wval = item.write_data;
        WK_CLEAR:  wval = old_val & ~item.write_data;
        WK_SET:    wval = old_val | item.write_data;
        WK_INVERT: wval = old_val ^ item.write_data;
        default:   wval = item.write_data;
      endcase
    end

    res = '0;
    if (!is_wr && mapped) begin
      res.read_data = old_val;
    end

    sys_step_next = sys_step;
    if (is_wr && item.reg_index == IX_SYSKEY) begin
      case (sys_step)
        STEP_IDLE: sys_step_next = (item.write_data == KEY_FIRST) ? STEP_KEY1 : STEP_IDLE;
        STEP_KEY1: sys_step_next = (item.write_data == KEY_SECOND) ? STEP_KEY2 : STEP_IDLE;
        default:   sys_step_next = STEP_IDLE;
      endcase
    end

    if (is_wr && item.reg_index == IX_SW_RESET && sys_step == STEP_KEY2 &&
        item.write_data[0]) begin
      res.soft_reset_pulse = 1'b1;
    end

    if (is_wr && item.reg_index == IX_NVM_CTRL && flash_step == STEP_KEY2 && wval[WR_BIT]) begin
      if (wval[3:0] == OP_ERASE || wval[3:0] == OP_PROGRAM) begin
        res.flash_request = 1'b1;
        res.flash_kind    = (wval[3:0] == OP_PROGRAM);
        res.flash_address = nvm_addr;
        res.flash_word    = nvm_data;
      end else begin
        res.unsupported_op = 1'b1;
      end
    end

    key1_hit        = 1'b0;
    flash_step_next = STEP_IDLE;
    if (is_wr && item.reg_index == IX_NVM_KEY && nvm_ctrl[WREN_BIT]) begin
      if (wval == KEY_FIRST) begin
        key1_hit        = 1'b1;
        flash_step_next = STEP_KEY1;
      end else if (flash_step == STEP_KEY1 && wval == KEY_SECOND) begin
        flash_step_next = STEP_KEY2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      osc_ctrl    <= OSC_CTRL_RESET;
      osc_tune    <= '0;
      debug_port  <= '0;
      syskey      <= '0;
      reset_cause <= '0;
      sw_reset    <= '0;
      nvm_ctrl    <= '0;
      nvm_key     <= '0;
      nvm_addr    <= '0;
      nvm_data    <= '0;
      nvm_src     <= '0;
      sys_step    <= STEP_IDLE;
      flash_step  <= STEP_IDLE;
    end else if (fire) begin
      sys_step   <= sys_step_next;
      flash_step <= flash_step_next;
      if (is_wr) begin
        case (item.reg_index)
          IX_OSC_CTRL:    osc_ctrl    <= wval;
          IX_OSC_TUNE:    osc_tune    <= wval;
          IX_DEBUG_PORT:  debug_port  <= wval;
          IX_SYSKEY:      syskey      <= wval;
          IX_RESET_CAUSE: reset_cause <= wval;
          IX_SW_RESET:    sw_reset    <= wval;
          IX_NVM_CTRL:    nvm_ctrl    <= wval;
          IX_NVM_KEY: begin
            nvm_key <= wval;
            if (key1_hit) begin
              nvm_ctrl[WR_BIT] <= 1'b0;
            end
          end
          IX_NVM_ADDR:    nvm_addr    <= wval;
          IX_NVM_DATA:    nvm_data    <= wval;
          IX_NVM_SRC:     nvm_src     <= wval;
          default:        ;
        endcase
      end else if (item.reg_index == IX_NVM_CTRL) begin
        nvm_ctrl[WR_BIT] <= 1'b0;
      end
    end
  end

  a_pulse_needs_unlock: assert property (@(posedge clk) disable iff (rst)
    (fire && res.soft_reset_pulse) |-> sys_step == STEP_KEY2)
    else $error("Software reset pulse without system unlock.");

  a_flash_seq_breaks: assert property (@(posedge clk) disable iff (rst)
    (fire && !(is_wr && item.reg_index == IX_NVM_KEY)) |=> flash_step == STEP_IDLE)
    else $error("Flash unlock sequence survived an unrelated access.");

  a_ctrl_read_clears_wr: assert property (@(posedge clk) disable iff (rst)
    (fire && !is_wr && item.reg_index == IX_NVM_CTRL) |=> !nvm_ctrl[WR_BIT])
    else $error("Reading flash control left the write bit set.");

  a_idle_holds_steps: assert property (@(posedge clk) disable iff (rst)
    !fire |=> ($stable(sys_step) && $stable(flash_step)))
    else $error("Unlock state changed without an access.");

  a_flash_start_needs_unlock: assert property (@(posedge clk) disable iff (rst)
    (fire && (res.flash_request || res.unsupported_op)) |-> flash_step == STEP_KEY2)
    else $error("Flash start reported without flash unlock.");

endmodule

`default_nettype wire

// ===== rtl/syscon_unlock_registers.sv =====
// Channel  | Direction | Payload                                          | Handshake
// req      | in        | command, reg_index, write_kind, write_data       | valid/ready
// rsp      | out       | read_data, soft_reset_pulse, flash_request,      | valid/ready
//          |           | flash_kind, flash_address, flash_word,           |
//          |           | unsupported_op                                   |
// cfg      | in        | cfg_wdata (device id)                            | cfg_we
//
// One beat is accepted per cycle while rsp does not stall; the beat is held in the input register,
// then its result is held in the result register and shown on rsp.
// Input and result registers lie around the register logic. Reset is synchronous
// and returns the control registers, valid flags and both unlock sequences to their defaults.
// A stall on rsp holds the result register and backs up into the input register and req.ready.
`default_nettype none

module syscon_unlock_registers (
  input  wire logic    clk,
  input  wire logic    rst,
  sucr_item_if.sink    req,
  sucr_result_if.source rsp,
  input  wire logic    cfg_we,
  input  wire logic [31:0] cfg_wdata
);
  import sucr_pkg::*;

  logic [DATA_W-1:0] device_id;
  logic              s1_valid;
  item_t             s1_item;
  logic              out_valid;
  result_t           out_res;
  result_t           res;
  logic              advance;
  logic              fire;
  logic              accept;

  assign advance   = !out_valid || rsp.ready;
  assign fire      = s1_valid && advance;
  assign req.ready = !s1_valid || advance;
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_id <= DEVICE_ID_RESET;
    end else if (cfg_we) begin
      device_id <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item.command    <= req.command;
      s1_item.reg_index  <= req.reg_index;
      s1_item.write_kind <= req.write_kind;
      s1_item.write_data <= req.write_data;
    end
  end

  sucr_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (s1_item),
    .device_id (device_id),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.read_data        = out_res.read_data;
  assign rsp.soft_reset_pulse = out_res.soft_reset_pulse;
  assign rsp.flash_request    = out_res.flash_request;
  assign rsp.flash_kind       = out_res.flash_kind;
  assign rsp.flash_address    = out_res.flash_address;
  assign rsp.flash_word       = out_res.flash_word;
  assign rsp.unsupported_op   = out_res.unsupported_op;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import sucr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned HOLD_CYCLES = 200;

  bit clk;
  logic rst = 1'b1;
  logic cfg_we;
  logic [31:0] cfg_wdata;

  sucr_item_if req_if ();
  sucr_result_if rsp_if ();

  syscon_unlock_registers DUT (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  logic [31:0] reg_shadow [0:11];
  logic [31:0] dev_id_q;
  step_t sys_step;
  step_t nvm_step;

  result_t pending_results [$];
  int failures = 0;
  int unsigned sent_count = 0;
  int unsigned cycle_count = 0;
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  bit hold_start = 1'b0;
  int unsigned stall_left = 0;
  int unsigned burst_left = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // The register block produces exactly one result per access.
  function automatic result_t predict_access(input item_t it);
    result_t r;
    logic [31:0] v;
    logic keep;
    r = '0;
    keep = 1'b0;
    if (it.reg_index == IX_DEV_ID) begin
      if (it.command == CMD_READ) r.read_data = dev_id_q;
    end else if (it.reg_index <= IX_NVM_SRC) begin
      if (it.command == CMD_READ) begin
        r.read_data = reg_shadow[it.reg_index];
        if (it.reg_index == IX_NVM_CTRL) reg_shadow[IX_NVM_CTRL][WR_BIT] = 1'b0;
      end else if (it.reg_index < IX_NVM_CTRL) begin
        reg_shadow[it.reg_index] = it.write_data;
        if (it.reg_index == IX_SYSKEY) begin
          case (sys_step)
            STEP_IDLE: sys_step = (it.write_data == KEY_FIRST) ? STEP_KEY1 : STEP_IDLE;
            STEP_KEY1: sys_step = (it.write_data == KEY_SECOND) ? STEP_KEY2 : STEP_IDLE;
            default: sys_step = STEP_IDLE;
          endcase
        end else if (it.reg_index == IX_SW_RESET) begin
          if (sys_step == STEP_KEY2 && it.write_data[0]) r.soft_reset_pulse = 1'b1;
        end
      end else begin
        case (wkind_t'(it.write_kind))
          WK_ASSIGN: v = it.write_data;
          WK_CLEAR: v = reg_shadow[it.reg_index] & ~it.write_data;
          WK_SET: v = reg_shadow[it.reg_index] | it.write_data;
          default: v = reg_shadow[it.reg_index] ^ it.write_data;
        endcase
        reg_shadow[it.reg_index] = v;
        if (it.reg_index == IX_NVM_CTRL) begin
          if (nvm_step == STEP_KEY2 && v[WR_BIT]) begin
            if (v[3:0] == OP_ERASE || v[3:0] == OP_PROGRAM) begin
              r.flash_request = 1'b1;
              r.flash_kind = (v[3:0] == OP_PROGRAM);
              r.flash_address = reg_shadow[IX_NVM_ADDR];
              r.flash_word = reg_shadow[IX_NVM_DATA];
            end else begin
              r.unsupported_op = 1'b1;
            end
          end
        end else if (it.reg_index == IX_NVM_KEY) begin
          if (reg_shadow[IX_NVM_CTRL][WREN_BIT] && v == KEY_FIRST) begin
            nvm_step = STEP_KEY1;
            keep = 1'b1;
            reg_shadow[IX_NVM_CTRL][WR_BIT] = 1'b0;
          end else if (nvm_step == STEP_KEY1 && reg_shadow[IX_NVM_CTRL][WREN_BIT] &&
                       v == KEY_SECOND) begin
            nvm_step = STEP_KEY2;
            keep = 1'b1;
          end
        end
      end
    end
    if (!keep) nvm_step = STEP_IDLE;
    return r;
  endfunction

  function automatic item_t access_of(input logic cmd, input logic [3:0] idx,
                                      input wkind_t kind, input logic [31:0] data);
    item_t it;
    it.command = cmd;
    it.reg_index = idx;
    it.write_kind = kind;
    it.write_data = data;
    return it;
  endfunction

  function automatic item_t random_access();
    logic [31:0] data;
    case ($urandom_range(0, 7))
      0: data = KEY_FIRST;
      1: data = KEY_SECOND;
      default: data = $urandom;
    endcase
    return access_of(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                     wkind_t'($urandom_range(0, 3)), data);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, actual %h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat arrived with no access outstanding");
        failures++;
      end else begin
        want = pending_results.pop_front();
        check_field("read_data", want.read_data, rsp_if.read_data);
        check_field("soft_reset_pulse", 32'(want.soft_reset_pulse),
                    32'(rsp_if.soft_reset_pulse));
        check_field("flash_request", 32'(want.flash_request), 32'(rsp_if.flash_request));
        check_field("flash_kind", 32'(want.flash_kind), 32'(rsp_if.flash_kind));
        check_field("flash_address", want.flash_address, rsp_if.flash_address);
        check_field("flash_word", want.flash_word, rsp_if.flash_word);
        check_field("unsupported_op", 32'(want.unsupported_op), 32'(rsp_if.unsupported_op));
      end
    end
  end

  always @(negedge clk) begin
    if (hold_start) begin
      hold_start = 1'b0;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      rsp_if.ready <= 1'b0;
    end else if (burst_left > 0) begin
      burst_left--;
      rsp_if.ready <= 1'b0;
    end else if (recv_idle && $urandom_range(0, 5) == 0) begin
      burst_left = $urandom_range(0, 7);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  task automatic send_access(input item_t it);
    int unsigned gap;
    if (send_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        req_if.valid <= 1'b0;
      end
    end
    @(negedge clk);
    req_if.valid <= 1'b1;
    req_if.command <= it.command;
    req_if.reg_index <= it.reg_index;
    req_if.write_kind <= it.write_kind;
    req_if.write_data <= it.write_data;
    do @(posedge clk); while (!req_if.ready);
    pending_results.push_back(predict_access(it));
    sent_count++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_reset_values();
    send_access(access_of(CMD_READ, IX_OSC_CTRL, WK_ASSIGN, 32'h0));
    send_access(access_of(CMD_READ, IX_DEV_ID, WK_ASSIGN, 32'h0));
    send_access(access_of(CMD_READ, IX_NVM_CTRL, WK_ASSIGN, 32'h0));
    send_access(access_of(CMD_READ, 4'd15, WK_INVERT, 32'hFFFF_FFFF));
  endtask

  task automatic test_unmapped_and_kinds();
    send_access(access_of(CMD_WRITE, 4'd12, WK_INVERT, 32'hFFFF_FFFF));
    send_access(access_of(CMD_READ, 4'd12, WK_ASSIGN, 32'h0));
    send_access(access_of(CMD_WRITE, IX_DEV_ID, WK_ASSIGN, 32'hFFFF_FFFF));
    send_access(access_of(CMD_WRITE, IX_NVM_SRC, WK_ASSIGN, 32'hFFFF_FFFF));
    send_access(access_of(CMD_WRITE, IX_NVM_SRC, WK_CLEAR, 32'h0F0F_00FF));
    send_access(access_of(CMD_READ, IX_NVM_SRC, WK_ASSIGN, 32'h0));
  endtask

  task automatic test_device_id(input logic [31:0] value);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    dev_id_q = value;
    send_access(access_of(CMD_READ, IX_DEV_ID, WK_ASSIGN, 32'h0));
    send_access(access_of(CMD_WRITE, IX_DEV_ID, WK_ASSIGN, ~value));
    send_access(access_of(CMD_READ, IX_DEV_ID, WK_ASSIGN, 32'h0));
  endtask

  task automatic test_system_unlock();
    send_access(access_of(CMD_WRITE, IX_SYSKEY, WK_ASSIGN, KEY_FIRST));
    send_access(access_of(CMD_WRITE, IX_SYSKEY, WK_ASSIGN, KEY_SECOND));
    send_access(access_of(CMD_WRITE, IX_SW_RESET, WK_ASSIGN, 32'h0000_0001));
    send_access(access_of(CMD_WRITE, IX_SW_RESET, WK_ASSIGN, 32'hFFFF_FFFE));
    send_access(access_of(CMD_WRITE, IX_SYSKEY, WK_ASSIGN, KEY_FIRST));
    send_access(access_of(CMD_WRITE, IX_SW_RESET, WK_ASSIGN, 32'hFFFF_FFFF));
    send_access(access_of(CMD_WRITE, IX_SYSKEY, WK_ASSIGN, KEY_SECOND));
  endtask

  task automatic test_flash_unlock();
    logic [31:0] wren;
    logic [31:0] wr;
    wren = 32'h1 << WREN_BIT;
    wr = 32'h1 << WR_BIT;
    send_access(access_of(CMD_WRITE, IX_NVM_ADDR, WK_ASSIGN, 32'hFFFF_FFFF));
    send_access(access_of(CMD_WRITE, IX_NVM_DATA, WK_ASSIGN, 32'h0));
    send_access(access_of(CMD_WRITE, IX_NVM_CTRL, WK_ASSIGN, wren | OP_ERASE));
    send_access(access_of(CMD_WRITE, IX_NVM_KEY, WK_ASSIGN, KEY_FIRST));
    send_access(access_of(CMD_WRITE, IX_NVM_KEY, WK_ASSIGN, KEY_SECOND));
    send_access(access_of(CMD_WRITE, IX_NVM_CTRL, WK_SET, wr));
    send_access(access_of(CMD_READ, IX_NVM_CTRL, WK_ASSIGN, 32'h0));
    send_access(access_of(CMD_WRITE, IX_NVM_CTRL, WK_INVERT, wr));
    send_access(access_of(CMD_WRITE, IX_NVM_KEY, WK_ASSIGN, KEY_FIRST));
    send_access(access_of(CMD_WRITE, IX_NVM_KEY, WK_ASSIGN, KEY_SECOND));
    send_access(access_of(CMD_WRITE, IX_NVM_CTRL, WK_ASSIGN, wren | wr | 32'h2));
    send_access(access_of(CMD_WRITE, IX_NVM_KEY, WK_ASSIGN, KEY_FIRST));
    send_access(access_of(CMD_WRITE, IX_NVM_KEY, WK_ASSIGN, KEY_SECOND));
    send_access(access_of(CMD_WRITE, IX_NVM_CTRL, WK_ASSIGN, wren | wr | OP_PROGRAM));
  endtask

  task automatic system_sequence();
    send_access(access_of(CMD_WRITE, IX_SYSKEY, WK_ASSIGN,
                          ($urandom_range(0, 7) == 0) ? $urandom : KEY_FIRST));
    send_access(access_of(CMD_WRITE, IX_SYSKEY, wkind_t'($urandom_range(0, 3)),
                          ($urandom_range(0, 7) == 0) ? $urandom : KEY_SECOND));
    if ($urandom_range(0, 5) == 0) send_access(random_access());
    send_access(access_of(CMD_WRITE, IX_SW_RESET, WK_ASSIGN,
                          $urandom | ($urandom_range(0, 3) != 0)));
  endtask

  task automatic flash_sequence();
    logic [3:0] op;
    logic [31:0] ctrl;
    case ($urandom_range(0, 4))
      0, 1: op = OP_ERASE;
      2, 3: op = OP_PROGRAM;
      default: op = 4'($urandom_range(0, 15));
    endcase
    ctrl = ($urandom & 32'hFFFF_3FF0) | op;
    if ($urandom_range(0, 7) != 0) ctrl[WREN_BIT] = 1'b1;
    send_access(access_of(CMD_WRITE, IX_NVM_ADDR, wkind_t'($urandom_range(0, 3)), $urandom));
    send_access(access_of(CMD_WRITE, IX_NVM_DATA, wkind_t'($urandom_range(0, 3)), $urandom));
    send_access(access_of(CMD_WRITE, IX_NVM_CTRL, WK_ASSIGN, ctrl));
    send_access(access_of(CMD_WRITE, IX_NVM_KEY, WK_ASSIGN,
                          ($urandom_range(0, 9) == 0) ? $urandom : KEY_FIRST));
    send_access(access_of(CMD_WRITE, IX_NVM_KEY, WK_ASSIGN,
                          ($urandom_range(0, 9) == 0) ? $urandom : KEY_SECOND));
    if ($urandom_range(0, 7) == 0) send_access(random_access());
    case ($urandom_range(0, 3))
      0: send_access(access_of(CMD_WRITE, IX_NVM_CTRL, WK_INVERT, 32'h1 << WR_BIT));
      1: send_access(access_of(CMD_WRITE, IX_NVM_CTRL, WK_ASSIGN,
                               ctrl | (32'h1 << WR_BIT)));
      default: send_access(access_of(CMD_WRITE, IX_NVM_CTRL, WK_SET,
                                     (32'h1 << WR_BIT) | $urandom_range(0, 15)));
    endcase
    if ($urandom_range(0, 1) == 0) send_access(access_of(CMD_READ, IX_NVM_CTRL, WK_ASSIGN,
                                                         $urandom));
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned target;
    target = sent_count + count;
    while (sent_count < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2: system_sequence();
        3, 4, 5, 6: flash_sequence();
        default: send_access(random_access());
      endcase
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    hold_start = 1'b1;
    repeat (40) send_access(random_access());
    wait_idle();
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.command = CMD_READ;
    req_if.reg_index = IX_OSC_CTRL;
    req_if.write_kind = WK_ASSIGN;
    req_if.write_data = '0;
    rsp_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    for (int i = 0; i < 12; i++) reg_shadow[i] = '0;
    reg_shadow[IX_OSC_CTRL] = OSC_CTRL_RESET;
    dev_id_q = DEVICE_ID_RESET;
    sys_step = STEP_IDLE;
    nvm_step = STEP_IDLE;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_unmapped_and_kinds();
    test_device_id(32'h0);
    test_system_unlock();
    test_flash_unlock();
    test_device_id(32'hFFFF_FFFF);
    test_backpressure();
    run_random(250);
    test_device_id($urandom);
    run_random(250);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    run_random(100);
    wait_idle();

    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sucr_pkg.sv
rtl/sucr_item_if.sv
rtl/sucr_result_if.sv
rtl/sucr_regs.sv
rtl/syscon_unlock_registers.sv
tb/tb.sv
